@@ src/utp_pkg.sv @@
// ----------------------------------------------------------------------------
// utp_pkg: shared types and constants for the up-counting timer
// Holds the register offsets, write masks, request kinds and the word structs.
// ----------------------------------------------------------------------------
`default_nettype none

package utp_pkg;

	// request kind carried in the input word
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_t;

	// register offsets inside the 1 KiB window
	localparam logic [9:0] OFF_CR1  = 10'h000;
	localparam logic [9:0] OFF_CR2  = 10'h004;
	localparam logic [9:0] OFF_DIER = 10'h00c;
	localparam logic [9:0] OFF_SR   = 10'h010;
	localparam logic [9:0] OFF_CNT  = 10'h024;
	localparam logic [9:0] OFF_PSC  = 10'h028;
	localparam logic [9:0] OFF_ARR  = 10'h02c;

	// writable bits of the control registers
	localparam logic [12:0] CR1_MASK  = 13'h188f;
	localparam logic [23:0] DIER_MASK = 24'hf05f5f;

	// control register bit positions
	localparam int unsigned CR1_CEN = 0;
	localparam int unsigned CR1_OPM = 3;
	localparam int unsigned DIER_UIE = 0;

	// one input word
	typedef struct packed {
		req_t        req_type;
		logic [9:0]  reg_offset;
		logic [31:0] write_data;
	} item_t;

	// one result word
	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        update_event;
	} result_t;

endpackage

`default_nettype wire

@@ src/utp_core.sv @@
// ----------------------------------------------------------------------------
// utp_core: timer register file, prescaler and counter
// Applies one word per strobe to the timer state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module utp_core #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire                    cfg_wdata,
	input  wire                    go,
	input  utp_pkg::item_t         item,
	output utp_pkg::result_t       res
);

	logic                   lp_mode_q;
	logic [12:0]            cr1_q, cr1_n;
	logic [23:0]            dier_q, dier_n;
	logic                   uif_q, uif_n;
	logic [15:0]            psc_q, psc_n;
	logic [15:0]            pcnt_q, pcnt_n;
	logic [COUNT_WIDTH-1:0] arr_q, arr_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic                   irq_q, irq_n;
	logic [31:0]            rdata;
	logic                   upd;

	// low-power mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_mode_q <= 1'b0;
		end else if (cfg_we) begin
			lp_mode_q <= cfg_wdata;
		end
	end

	// next state and result for the word being applied
	always_comb begin
		cr1_n  = cr1_q;
		dier_n = dier_q;
		uif_n  = uif_q;
		psc_n  = psc_q;
		pcnt_n = pcnt_q;
		arr_n  = arr_q;
		cnt_n  = cnt_q;
		irq_n  = irq_q;
		rdata  = 32'd0;
		upd    = 1'b0;
		case (item.req_type)
			utp_pkg::REQ_TICK: begin
				if (cr1_q[utp_pkg::CR1_CEN]) begin
					if (pcnt_q >= psc_q) begin
						pcnt_n = 16'd0;
						// counter step, blocked while the reload value is zero
						if (arr_q != '0) begin
							if (cnt_q == arr_q) begin
								cnt_n = '0;
								uif_n = 1'b1;
								upd   = 1'b1;
								if (dier_q[utp_pkg::DIER_UIE]) begin
									irq_n = 1'b1;
								end
								if (cr1_q[utp_pkg::CR1_OPM]) begin
									cr1_n[utp_pkg::CR1_CEN] = 1'b0;
								end
							end else begin
								cnt_n = cnt_q + COUNT_WIDTH'(1);
							end
						end
					end else begin
						pcnt_n = pcnt_q + 16'd1;
					end
				end
			end
			utp_pkg::REQ_READ: begin
				if (!lp_mode_q) begin
					case (item.reg_offset)
						utp_pkg::OFF_CR1:  rdata = 32'(cr1_q);
						utp_pkg::OFF_CR2:  rdata = 32'd0;
						utp_pkg::OFF_DIER: rdata = 32'(dier_q);
						utp_pkg::OFF_SR:   rdata = 32'(uif_q);
						utp_pkg::OFF_CNT:  rdata = 32'(cnt_q);
						utp_pkg::OFF_PSC:  rdata = 32'(psc_q);
						utp_pkg::OFF_ARR:  rdata = 32'(arr_q);
						default:           rdata = 32'd0;
					endcase
				end
			end
			utp_pkg::REQ_WRITE: begin
				if (!lp_mode_q) begin
					case (item.reg_offset)
						utp_pkg::OFF_CR1: begin
							cr1_n = item.write_data[12:0] & utp_pkg::CR1_MASK;
						end
						utp_pkg::OFF_DIER: begin
							dier_n = item.write_data[23:0] & utp_pkg::DIER_MASK;
						end
						utp_pkg::OFF_SR: begin
							// clearing the flag also drops the interrupt line
							uif_n = item.write_data[0];
							if (!item.write_data[0]) begin
								irq_n = 1'b0;
							end
						end
						utp_pkg::OFF_CNT: begin
							cnt_n = item.write_data[COUNT_WIDTH-1:0];
						end
						utp_pkg::OFF_PSC: begin
							psc_n  = item.write_data[15:0];
							pcnt_n = 16'd0;
						end
						utp_pkg::OFF_ARR: begin
							arr_n = item.write_data[COUNT_WIDTH-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr1_q  <= '0;
			dier_q <= '0;
			uif_q  <= 1'b0;
			psc_q  <= '0;
			pcnt_q <= '0;
			arr_q  <= '0;
			cnt_q  <= '0;
			irq_q  <= 1'b0;
		end else if (go) begin
			cr1_q  <= cr1_n;
			dier_q <= dier_n;
			uif_q  <= uif_n;
			psc_q  <= psc_n;
			pcnt_q <= pcnt_n;
			arr_q  <= arr_n;
			cnt_q  <= cnt_n;
			irq_q  <= irq_n;
		end
	end

	// result of the word being applied
	assign res.read_data    = rdata;
	assign res.irq_level    = irq_n;
	assign res.update_event = upd;

endmodule

`default_nettype wire

@@ src/upcounting_timer_with_prescaler.sv @@
// ----------------------------------------------------------------------------
// upcounting_timer_with_prescaler: register-mapped up-counting timer
// An accepted word waits in the input register until the result register is
// free or being drained, then it is applied and its result is registered.
// Throughput: one word per cycle unless results stall; the input and result
// registers decouple the two sides, so a stalled result still lets one word in.
// Reset: arst_n clears all timer registers, low-power mode and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module upcounting_timer_with_prescaler #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration: low-power mode
	input  wire        cfg_we,
	input  wire        cfg_wdata,
	// input words
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [47:0] s_axis_tdata,  // reg_offset[9:0], write_data[41:10], zero pad
	input  wire [1:0]  s_axis_tuser,  // req_type[1:0]
	// result words
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [39:0] m_axis_tdata  // read_data[31:0], irq_level[32],
	                                   // update_event[33], zero pad
);

	logic              valid_s1;
	utp_pkg::item_t    item_s1;
	logic              out_valid_q;
	utp_pkg::result_t  out_q;
	utp_pkg::result_t  res;
	logic              advance;

	// result register free or being drained
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.req_type   <= utp_pkg::req_t'(s_axis_tuser);
			item_s1.reg_offset <= s_axis_tdata[9:0];
			item_s1.write_data <= s_axis_tdata[41:10];
		end
	end

	// timer state and result logic
	utp_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.go        (valid_s1 && advance),
		.item      (item_s1),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.update_event, out_q.irq_level, out_q.read_data};

endmodule

`default_nettype wire

@@ test/upcounting_timer_with_prescaler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcounting_timer_with_prescaler_tb: self-checking bench for the timer
// Drives register reads, writes and input ticks as words, with random gaps on
// both sides. A scoreboard keeps its own copy of the timer registers, predicts
// the result word of every accepted input word and checks each result in order.
// Low-power mode is switched between phases while the timer is drained.
// ----------------------------------------------------------------------------

module upcounting_timer_with_prescaler_tb;
	import utp_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

	// scoreboard: timer register copy plus the queue of predicted results
	class timer_tracker;
		bit          low_power;
		logic [12:0] ctrl;
		logic [23:0] irq_en;
		bit          upd_flag;
		logic [15:0] psc;
		logic [31:0] reload;
		logic [31:0] count;
		logic [15:0] psc_count;
		bit          irq;
		result_t     pending[$];
		int unsigned errors;

		function new();
			low_power = 0;
			ctrl = '0;
			irq_en = '0;
			upd_flag = 0;
			psc = '0;
			reload = '0;
			count = '0;
			psc_count = '0;
			irq = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			errors++;
		endtask

		// register value seen by a bus read
		function logic [31:0] read_reg(logic [9:0] off);
			if (low_power)
				return '0;
			case (off)
				OFF_CR1:  return {19'd0, ctrl};
				OFF_DIER: return {8'd0, irq_en};
				OFF_SR:   return {31'd0, upd_flag};
				OFF_CNT:  return count;
				OFF_PSC:  return {16'd0, psc};
				OFF_ARR:  return reload;
				default:  return '0;
			endcase
		endfunction

		function void write_reg(logic [9:0] off, logic [31:0] data);
			if (low_power)
				return;
			case (off)
				OFF_CR1:  ctrl = data[12:0] & CR1_MASK;
				OFF_DIER: irq_en = data[23:0] & DIER_MASK;
				OFF_SR: begin
					upd_flag = data[0];
					if (!data[0])
						irq = 0;
				end
				OFF_CNT:  count = data;
				OFF_PSC: begin
					psc = data[15:0];
					psc_count = '0;
				end
				OFF_ARR:  reload = data;
				default: ;
			endcase
		endfunction

		// one input clock tick, returns the update event
		function bit tick();
			if (!ctrl[CR1_CEN])
				return 0;
			if (psc_count < psc) begin
				psc_count = psc_count + 16'd1;
				return 0;
			end
			psc_count = '0;
			if (reload == '0)
				return 0;
			if (count == reload) begin
				count = '0;
				upd_flag = 1;
				if (irq_en[DIER_UIE])
					irq = 1;
				if (ctrl[CR1_OPM])
					ctrl[CR1_CEN] = 1'b0;
				return 1;
			end
			count = count + 32'd1;
			return 0;
		endfunction

		// predict the result of an accepted input word
		function void note_word(logic [1:0] req, logic [9:0] off, logic [31:0] data);
			result_t res;
			res = '0;
			if (req == REQ_TICK)
				res.update_event = tick();
			else if (req == REQ_READ)
				res.read_data = read_reg(off);
			else if (req == REQ_WRITE)
				write_reg(off, data);
			res.irq_level = irq;
			pending.push_back(res);
		endfunction

		task check_word(logic [39:0] word);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result word 0x%010h with nothing pending", word));
				return;
			end
			want = pending.pop_front();
			if (word[31:0] !== want.read_data)
				report($sformatf("read_data 0x%08h, predicted 0x%08h",
					word[31:0], want.read_data));
			if (word[32] !== want.irq_level)
				report($sformatf("irq_level %b, predicted %b", word[32], want.irq_level));
			if (word[33] !== want.update_event)
				report($sformatf("update_event %b, predicted %b",
					word[33], want.update_event));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	timer_tracker tracker = new();
	bit           quiet = 1'b0;
	int unsigned  stalled_cycles = 0;
	int unsigned  counted_words = 0;

	upcounting_timer_with_prescaler #(
		.COUNT_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// idle length: mostly none or short, a few long, none in quiet stretches
	function automatic int unsigned pick_idle();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [9:0] pick_offset();
		if ($urandom_range(0, 4) == 0)
			return 10'($urandom_range(0, 1023));
		case ($urandom_range(0, 6))
			0: return OFF_CR1;
			1: return OFF_CR2;
			2: return OFF_DIER;
			3: return OFF_SR;
			4: return OFF_CNT;
			5: return OFF_PSC;
			default: return OFF_ARR;
		endcase
	endfunction

	// quiet stretches come and go for both sides
	initial begin
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			quiet = ~quiet;
		end
	end

	// offer one word after a random gap and wait until it is taken
	task automatic push_word(input logic [1:0] req, input logic [9:0] off,
			input logic [31:0] data);
		int unsigned gap;
		gap = pick_idle();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, data, off};
		s_axis_tuser <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_word(req, off, data);
		counted_words++;
	endtask

	task automatic wait_drained();
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// low-power mode is only switched while the timer is idle
	task automatic set_low_power(input bit lp);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= lp;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.low_power = lp;
	endtask

	task automatic push_noise();
		push_word(2'($urandom_range(0, 3)), pick_offset(), $urandom);
	endtask

	// program a small timer setup, then run ticks mixed with accesses
	task automatic run_scenario();
		logic [31:0] arr;
		logic [31:0] data;
		int unsigned n;
		int unsigned r;
		arr = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
		if ($urandom_range(0, 11) == 0)
			data = $urandom;
		else
			data = ($urandom & 32'hffff_0000) | 32'($urandom_range(0, 2));
		push_word(REQ_WRITE, OFF_PSC, data);
		push_word(REQ_WRITE, OFF_ARR, arr);
		if ($urandom_range(0, 4) == 0)
			data = 32'hffff_ffff - 32'($urandom_range(0, 2));
		else
			data = $urandom_range(0, arr);
		push_word(REQ_WRITE, OFF_CNT, data);
		push_word(REQ_WRITE, OFF_DIER, $urandom);
		if ($urandom_range(0, 1) == 0)
			push_word(REQ_WRITE, OFF_SR, $urandom);
		data = $urandom;
		data[CR1_CEN] = ($urandom_range(0, 9) != 0);
		push_word(REQ_WRITE, OFF_CR1, data);
		n = $urandom_range(6, 24);
		repeat (n) begin
			r = $urandom_range(0, 19);
			if (r < 14)
				push_word(REQ_TICK, pick_offset(), $urandom);
			else if (r < 17)
				push_word(REQ_READ, pick_offset(), $urandom);
			else if (r < 18)
				push_word(REQ_WRITE, OFF_SR, $urandom);
			else if (r < 19)
				push_noise();
			else
				push_word(REQ_WRITE, OFF_CNT, $urandom_range(0, 7));
		end
	endtask

	// result side: random stalls, check every accepted word
	initial begin
		int unsigned hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tdata);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				hold = pick_idle();
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: register extremes and corner cases
		set_low_power(1'b0);
		push_word(REQ_READ, OFF_CR1, 32'd0);
		push_word(REQ_WRITE, OFF_CR1, 32'hffff_ffff);
		push_word(REQ_READ, OFF_CR1, 32'hffff_ffff);
		push_word(REQ_WRITE, OFF_CR2, 32'hffff_ffff);
		push_word(REQ_READ, OFF_CR2, 32'd0);
		push_word(REQ_WRITE, OFF_DIER, 32'hffff_ffff);
		push_word(REQ_READ, OFF_DIER, 32'd0);
		push_word(REQ_WRITE, OFF_PSC, 32'hffff_ffff);
		push_word(REQ_READ, OFF_PSC, 32'd0);
		push_word(REQ_WRITE, OFF_PSC, 32'd0);
		// reload of zero blocks the counter
		push_word(REQ_TICK, 10'h3ff, 32'hffff_ffff);
		push_word(REQ_WRITE, OFF_ARR, 32'd2);
		// counter above reload rolls over through all ones without update
		push_word(REQ_WRITE, OFF_CNT, 32'hffff_ffff);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		// wrap with interrupt, one-pulse then stops the timer
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_READ, OFF_SR, 32'd0);
		push_word(REQ_WRITE, OFF_SR, 32'hffff_ffff);
		push_word(REQ_WRITE, OFF_SR, 32'hffff_fffe);
		// unaligned and unmapped offsets, unknown request kind
		push_word(REQ_READ, 10'h3ff, 32'd0);
		push_word(REQ_WRITE, 10'h001, 32'hffff_ffff);
		push_word(REQ_UNKNOWN, OFF_CR1, 32'hffff_ffff);
		push_word(REQ_WRITE, OFF_ARR, 32'hffff_ffff);
		push_word(REQ_READ, OFF_ARR, 32'd0);
		push_word(REQ_WRITE, OFF_ARR, 32'd2);
		push_word(REQ_WRITE, OFF_CR1, 32'd1);

		// low-power: accesses ignored, ticks keep running
		set_low_power(1'b1);
		push_word(REQ_READ, OFF_CR1, 32'd0);
		push_word(REQ_WRITE, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_TICK, OFF_CR1, 32'd0);
		push_word(REQ_READ, OFF_CNT, 32'd0);
		set_low_power(1'b0);
		push_word(REQ_READ, OFF_CNT, 32'd0);

		// random: mostly well-formed setups, some noise
		while (counted_words < 250) begin
			if ($urandom_range(0, 5) == 0)
				push_noise();
			else
				run_scenario();
		end
		set_low_power(1'b1);
		repeat (40) begin
			if ($urandom_range(0, 2) == 0)
				push_noise();
			else
				push_word(REQ_TICK, pick_offset(), $urandom);
		end
		set_low_power(1'b0);
		while (counted_words < 400) begin
			if ($urandom_range(0, 5) == 0)
				push_noise();
			else
				run_scenario();
		end
		s_axis_tvalid <= 1'b0;

		// drain and let any stray result show up
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
